// ===== src/rcsa_pkg.sv =====
package rcsa_pkg;

    // Stick thresholds in microseconds
    localparam logic [11:0] THR_LOW    = 12'd1050;
    localparam logic [11:0] YAW_HIGH   = 12'd1950;
    localparam logic [11:0] PITCH_LOW  = 12'd1200;
    localparam logic [11:0] ROLL_LOW   = 12'd1050;
    localparam logic [12:0] CENTER     = 13'd1500;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned SP_W       = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNLOCK_TICKS = 3'd0,
        CFG_LOCK_TICKS   = 3'd1,
        CFG_YAW_GAIN     = 3'd2,
        CFG_PITCH_GAIN   = 3'd3,
        CFG_ROLL_GAIN    = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ST_LOCKED = 1'b0,
        ST_ARMED  = 1'b1
    } t_arm_state;

    typedef struct packed {
        logic [CFG_W-1:0] unlock_ticks;
        logic [CFG_W-1:0] lock_ticks;
        logic [CFG_W-1:0] yaw_gain;
        logic [CFG_W-1:0] pitch_gain;
        logic [CFG_W-1:0] roll_gain;
    } t_cfg;

    typedef struct packed {
        logic thr_low;
        logic arm_gesture;
    } t_stick_flags;

    typedef struct packed {
        logic armed;
        logic arm_event;
        logic disarm_event;
        logic posture_valid;
    } t_arm_status;

endpackage

// ===== src/rcsa_cfg_regs.sv =====
module rcsa_cfg_regs
    import rcsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_ticks <= 16'd500;
            r_cfg.lock_ticks   <= 16'd1000;
            r_cfg.yaw_gain     <= '0;
            r_cfg.pitch_gain   <= '0;
            r_cfg.roll_gain    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_UNLOCK_TICKS: r_cfg.unlock_ticks <= i_cfg_data;
                CFG_LOCK_TICKS:   r_cfg.lock_ticks   <= i_cfg_data;
                CFG_YAW_GAIN:     r_cfg.yaw_gain     <= i_cfg_data;
                CFG_PITCH_GAIN:   r_cfg.pitch_gain   <= i_cfg_data;
                CFG_ROLL_GAIN:    r_cfg.roll_gain    <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/rcsa_setpoint.sv =====
module rcsa_setpoint
    import rcsa_pkg::*;
(
    input  logic [CFG_W-1:0]   i_gain,
    input  logic [PULSE_W-1:0] i_pulse,
    input  logic               i_reverse,  // use center - pulse
    input  logic               i_enable,
    output logic [SP_W-1:0]    o_setpoint
);

    logic signed [PULSE_W:0]       w_diff;
    logic                          w_neg;
    logic [PULSE_W-1:0]            w_mag;
    logic [CFG_W+PULSE_W-1:0]      w_prod;
    logic [SP_W-1:0]               w_q;

    // Offset magnitude never exceeds 2595, so 12 bits hold it
    assign w_diff = $signed({1'b0, i_pulse}) - $signed(CENTER);
    assign w_neg  = i_reverse ? (!w_diff[PULSE_W] && (w_diff != '0)) : w_diff[PULSE_W];
    assign w_mag  = w_diff[PULSE_W] ? PULSE_W'(-w_diff) : w_diff[PULSE_W-1:0];
    assign w_prod = i_gain * w_mag;
    assign w_q    = {1'b0, w_prod[CFG_W+PULSE_W-1:8]};

    always_comb begin
        if (!i_enable || (w_prod[CFG_W+PULSE_W-1:16] == '0)) begin
            o_setpoint = '0;  // under one degree: deadband
        end else if (w_neg) begin
            o_setpoint = -w_q;
        end else begin
            o_setpoint = w_q;
        end
    end

endmodule

// ===== src/rcsa_arm_fsm.sv =====
module rcsa_arm_fsm
    import rcsa_pkg::*;
#(
    parameter int unsigned HOLD_COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_stick_flags     i_flags,
    input  logic [CFG_W-1:0] i_unlock_ticks,
    input  logic [CFG_W-1:0] i_lock_ticks,
    output t_arm_status      o_status
);

    localparam int unsigned CMP_W = (HOLD_COUNT_WIDTH > CFG_W) ? HOLD_COUNT_WIDTH : CFG_W;

    t_arm_state                  r_state, n_state;
    logic [HOLD_COUNT_WIDTH-1:0] r_arm_cnt, n_arm_cnt;
    logic [HOLD_COUNT_WIDTH-1:0] r_dis_cnt, n_dis_cnt;
    logic [HOLD_COUNT_WIDTH-1:0] w_arm_inc, w_dis_inc;
    logic                        w_arm_hit, w_dis_hit;

    // Saturating hold counts; the arm count clears when the gesture breaks, the disarm count when throttle leaves low
    assign w_arm_inc = !i_flags.arm_gesture ? '0 :
                       (&r_arm_cnt) ? r_arm_cnt : r_arm_cnt + 1'b1;
    assign w_dis_inc = !i_flags.thr_low ? '0 :
                       (&r_dis_cnt) ? r_dis_cnt : r_dis_cnt + 1'b1;
    assign w_arm_hit = CMP_W'(w_arm_inc) >= CMP_W'(i_unlock_ticks);
    assign w_dis_hit = CMP_W'(w_dis_inc) >  CMP_W'(i_lock_ticks);

    always_comb begin
        n_state   = r_state;
        n_arm_cnt = r_arm_cnt;
        n_dis_cnt = r_dis_cnt;
        case (r_state)
            ST_LOCKED: begin
                if (w_arm_hit) begin
                    n_state   = ST_ARMED;
                    n_arm_cnt = '0;
                    n_dis_cnt = '0;
                end else begin
                    n_arm_cnt = w_arm_inc;
                end
            end
            ST_ARMED: begin
                if (w_dis_hit) begin
                    n_state   = ST_LOCKED;
                    n_arm_cnt = '0;
                    n_dis_cnt = '0;
                end else begin
                    n_dis_cnt = w_dis_inc;
                end
            end
            default: begin
                n_state = ST_LOCKED;
            end
        endcase
    end

    always_comb begin
        o_status = '0;
        case (r_state)
            ST_LOCKED: begin
                o_status.armed     = w_arm_hit;
                o_status.arm_event = w_arm_hit;
            end
            ST_ARMED: begin
                o_status.armed         = !w_dis_hit;
                o_status.disarm_event  = w_dis_hit;
                o_status.posture_valid = !w_dis_hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOCKED;
            r_arm_cnt <= '0;
            r_dis_cnt <= '0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_arm_cnt <= n_arm_cnt;
            r_dis_cnt <= n_dis_cnt;
        end
    end

endmodule

// ===== src/rc_stick_arming_and_setpoints_top.sv =====
// Flow: an accepted item waits in the input register and moves to the result
//   register, and so to the outputs, once the result register is free.
// Throughput: one item per cycle unless stalled. While a result waits, the input
//   register takes one more item; input ready then drops until it is taken.
// Reset (synchronous, active low): locked, both hold counts zero, registers at
//   their defaults (unlock 500, lock 1000, gains 0), both stages empty.
module rc_stick_arming_and_setpoints_top
    import rcsa_pkg::*;
#(
    parameter int unsigned HOLD_COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // Input item: one control tick of four channel pulses
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PULSE_W-1:0]   i_throttle_pulse,
    input  logic [PULSE_W-1:0]   i_yaw_pulse,
    input  logic [PULSE_W-1:0]   i_pitch_pulse,
    input  logic [PULSE_W-1:0]   i_roll_pulse,

    // Result item
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_armed,
    output logic                 o_arm_event,
    output logic                 o_disarm_event,
    output logic                 o_posture_valid,
    output logic [PULSE_W-1:0]   o_throttle_out,
    output logic signed [SP_W-1:0] o_yaw_setpoint,
    output logic signed [SP_W-1:0] o_pitch_setpoint,
    output logic signed [SP_W-1:0] o_roll_setpoint
);

    t_cfg                w_cfg;
    t_stick_flags        w_flags;
    t_arm_status         w_status;
    logic                w_out_load;
    logic                w_step;
    logic                w_sp_en;
    logic [SP_W-1:0]     w_yaw_sp, w_pitch_sp, w_roll_sp;

    // Input register
    logic                r_in_valid;
    logic [PULSE_W-1:0]  r_thr, r_yaw, r_pit, r_rol;

    // Result register
    logic                r_out_valid;
    t_arm_status         r_status;
    logic [PULSE_W-1:0]  r_thr_out;
    logic [SP_W-1:0]     r_yaw_sp, r_pitch_sp, r_roll_sp;

    rcsa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Result register can take a new item when empty or being drained.
    // The item in the input register advances exactly then; the arming
    // state moves with it, so the next item sees this item's outcome.
    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_out_load;
    assign o_in_ready = !r_in_valid || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_thr <= i_throttle_pulse;
            r_yaw <= i_yaw_pulse;
            r_pit <= i_pitch_pulse;
            r_rol <= i_roll_pulse;
        end
    end

    // Stick gesture decode
    assign w_flags.thr_low     = r_thr < THR_LOW;
    assign w_flags.arm_gesture = (r_thr < THR_LOW) && (r_yaw > YAW_HIGH) &&
                                 (r_pit < PITCH_LOW) && (r_rol < ROLL_LOW);

    rcsa_arm_fsm #(
        .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
    ) u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_flags        (w_flags),
        .i_unlock_ticks (w_cfg.unlock_ticks),
        .i_lock_ticks   (w_cfg.lock_ticks),
        .o_status       (w_status)
    );

    // Setpoints only on a posture tick with throttle at or above the low mark
    assign w_sp_en = w_status.posture_valid && !w_flags.thr_low;

    rcsa_setpoint u_yaw_sp (
        .i_gain     (w_cfg.yaw_gain),
        .i_pulse    (r_yaw),
        .i_reverse  (1'b0),
        .i_enable   (w_sp_en),
        .o_setpoint (w_yaw_sp)
    );

    // Pitch is reversed: stick forward (short pulse) gives positive angle
    rcsa_setpoint u_pitch_sp (
        .i_gain     (w_cfg.pitch_gain),
        .i_pulse    (r_pit),
        .i_reverse  (1'b1),
        .i_enable   (w_sp_en),
        .o_setpoint (w_pitch_sp)
    );

    rcsa_setpoint u_roll_sp (
        .i_gain     (w_cfg.roll_gain),
        .i_pulse    (r_rol),
        .i_reverse  (1'b0),
        .i_enable   (w_sp_en),
        .o_setpoint (w_roll_sp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_status   <= w_status;
            r_thr_out  <= w_status.posture_valid ? r_thr : '0;
            r_yaw_sp   <= w_yaw_sp;
            r_pitch_sp <= w_pitch_sp;
            r_roll_sp  <= w_roll_sp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_armed          = r_status.armed;
    assign o_arm_event      = r_status.arm_event;
    assign o_disarm_event   = r_status.disarm_event;
    assign o_posture_valid  = r_status.posture_valid;
    assign o_throttle_out   = r_thr_out;
    assign o_yaw_setpoint   = $signed(r_yaw_sp);
    assign o_pitch_setpoint = $signed(r_pitch_sp);
    assign o_roll_setpoint  = $signed(r_roll_sp);

endmodule

// ===== src/rcsa_checker.sv =====
module rcsa_checker
    import rcsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 o_armed,
    input  logic                 o_arm_event,
    input  logic                 o_disarm_event,
    input  logic                 o_posture_valid,
    input  logic [PULSE_W-1:0]   o_throttle_out,
    input  logic [SP_W-1:0]      o_yaw_setpoint,
    input  logic [SP_W-1:0]      o_pitch_setpoint,
    input  logic [SP_W-1:0]      o_roll_setpoint
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_armed) && $stable(o_posture_valid) &&
             $stable(o_yaw_setpoint) && $stable(o_throttle_out)))
        else $error("result changed while stalled");

    a_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_arm_event && o_disarm_event) &&
                         (!o_arm_event || o_armed) && (!o_disarm_event || !o_armed)))
        else $error("event disagrees with armed state");

    a_posture_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_posture_valid) |-> (o_armed && !o_arm_event && !o_disarm_event))
        else $error("posture issued while not armed");

    a_no_posture_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_posture_valid) |->
            ((o_throttle_out == '0) && (o_yaw_setpoint == '0) &&
             (o_pitch_setpoint == '0) && (o_roll_setpoint == '0)))
        else $error("fields not cleared without posture");

    a_low_thr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_throttle_out < THR_LOW)) |->
            ((o_yaw_setpoint == '0) && (o_pitch_setpoint == '0) && (o_roll_setpoint == '0)))
        else $error("setpoints not zero at low throttle");

endmodule

bind rc_stick_arming_and_setpoints_top rcsa_checker u_rcsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_armed          (o_armed),
    .o_arm_event      (o_arm_event),
    .o_disarm_event   (o_disarm_event),
    .o_posture_valid  (o_posture_valid),
    .o_throttle_out   (o_throttle_out),
    .o_yaw_setpoint   (o_yaw_setpoint),
    .o_pitch_setpoint (o_pitch_setpoint),
    .o_roll_setpoint  (o_roll_setpoint)
);
